>>> design/vtep_pkg.sv
// Shared types and constants for the velocity to energy and pitch core.
// Used by vtep_energy, vtep_cell and velocity_to_energy_pitch_core.
package vtep_pkg;

    // Field widths
    localparam int VEL_W    = 32;
    localparam int ENERGY_W = 48;
    localparam int PITCH_W  = 24;
    localparam int COEFF_W  = 32;
    localparam int SHIFT_W  = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // CORDIC datapath widths: x/y hold magnitudes below 2^63 after the
    // 2^30 prescale and the CORDIC gain; z stays within +/-2^25.
    localparam int XY_W     = 64;
    localparam int Z_W      = 26;
    localparam int ATAN_W   = 22;
    localparam int PRESCALE = 30;
    localparam int TAB_N    = 32;

    localparam logic [PITCH_W-1:0] PITCH_MAX    = 24'd11796480;
    localparam logic [Z_W-1:0]     QUARTER_TURN = 26'd5898240;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_COEFF = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SHIFT = 8'd1;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_TAB [TAB_N] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    // Payload handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [ENERGY_W-1:0]    energy;
        logic                   zero;
    } t_cord;

endpackage

>>> design/vtep_energy.sv
// Front end: input conditioning, CORDIC seed and the six-stage energy pipeline.
// Depends on vtep_pkg.
module vtep_energy (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [vtep_pkg::VEL_W-1:0] i_vel_para,
    input  logic signed [vtep_pkg::VEL_W-1:0] i_vel_perp,
    input  logic [vtep_pkg::COEFF_W-1:0]   i_coeff,
    input  logic [vtep_pkg::SHIFT_W-1:0]   i_shift,
    output logic                           o_valid,
    input  logic                           i_ready,
    output vtep_pkg::t_cord                o_data
);
    import vtep_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_in_vld;

    // Payload registers per stage
    t_cord r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic [VEL_W-1:0]     r_ap, r_aq;
    logic [2*VEL_W-1:0]   r_sq_a, r_sq_b;
    logic [2*VEL_W-1:0]   r_sum;
    logic [2*VEL_W-1:0]   r_t, r_u;
    logic [3*VEL_W-1:0]   r_prod;

    // Stage 1 combinational: magnitudes, zero check, pre-rotation
    logic signed [VEL_W:0] w_neg_para, w_abs_perp, w_x0, w_y0;
    logic [VEL_W-1:0]      w_ap;
    logic [Z_W-1:0]        w_z0;
    logic                  w_zero;
    logic [3*VEL_W-1:0]    w_shifted;

    always_comb begin
        w_neg_para = -$signed({i_vel_para[VEL_W-1], i_vel_para});
        w_abs_perp = i_vel_perp[VEL_W-1] ? -$signed({i_vel_perp[VEL_W-1], i_vel_perp})
                                         : $signed({i_vel_perp[VEL_W-1], i_vel_perp});
        w_ap       = i_vel_para[VEL_W-1] ? w_neg_para[VEL_W-1:0] : i_vel_para;
        w_zero     = (i_vel_para == '0) && (i_vel_perp == '0);
        // left half-plane: turn by -90 degrees first
        if (w_neg_para[VEL_W]) begin
            w_x0 = w_abs_perp;
            w_y0 = $signed({i_vel_para[VEL_W-1], i_vel_para});
            w_z0 = QUARTER_TURN;
        end else begin
            w_x0 = w_neg_para;
            w_y0 = w_abs_perp;
            w_z0 = '0;
        end
    end

    // Handshake chain: a stage takes data when empty or draining
    assign w_in_vld = {r_vld[NSTG-2:0], i_valid};
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_in_vld[k];
                end
            end
        end
    end

    // Stage 1: seed and magnitudes
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && w_in_vld[0]) begin
            r_c1.x      <= $signed({w_x0[VEL_W], w_x0, {PRESCALE{1'b0}}});
            r_c1.y      <= $signed({w_y0[VEL_W], w_y0, {PRESCALE{1'b0}}});
            r_c1.z      <= $signed(w_z0);
            r_c1.energy <= '0;
            r_c1.zero   <= w_zero;
            r_ap        <= w_ap;
            r_aq        <= w_abs_perp[VEL_W-1:0];
        end
    end

    // Stage 2: squares (upper operand halves are zero: 32x32 multipliers)
    always_ff @(posedge i_clk) begin
        if (w_rdy[1] && w_in_vld[1]) begin
            r_c2   <= r_c1;
            r_sq_a <= {{VEL_W{1'b0}}, r_ap} * {{VEL_W{1'b0}}, r_ap};
            r_sq_b <= {{VEL_W{1'b0}}, r_aq} * {{VEL_W{1'b0}}, r_aq};
        end
    end

    // Stage 3: sum of squares, exact in 64 bits
    always_ff @(posedge i_clk) begin
        if (w_rdy[2] && w_in_vld[2]) begin
            r_c3  <= r_c2;
            r_sum <= r_sq_a + r_sq_b;
        end
    end

    // Stage 4: partial products with the coefficient
    always_ff @(posedge i_clk) begin
        if (w_rdy[3] && w_in_vld[3]) begin
            r_c4 <= r_c3;
            r_t  <= {{VEL_W{1'b0}}, r_sum[VEL_W-1:0]} * {{VEL_W{1'b0}}, i_coeff};
            r_u  <= {{VEL_W{1'b0}}, r_sum[2*VEL_W-1:VEL_W]} * {{VEL_W{1'b0}}, i_coeff};
        end
    end

    // Stage 5: combine partial products into the 96-bit product
    always_ff @(posedge i_clk) begin
        if (w_rdy[4] && w_in_vld[4]) begin
            r_c5   <= r_c4;
            r_prod <= {{VEL_W{1'b0}}, r_t} + {r_u, {VEL_W{1'b0}}};
        end
    end

    // Stage 6: right shift and saturate
    assign w_shifted = r_prod >> i_shift;
    always_ff @(posedge i_clk) begin
        if (w_rdy[5] && w_in_vld[5]) begin
            r_c6.x      <= r_c5.x;
            r_c6.y      <= r_c5.y;
            r_c6.z      <= r_c5.z;
            r_c6.zero   <= r_c5.zero;
            r_c6.energy <= (|w_shifted[3*VEL_W-1:ENERGY_W]) ? {ENERGY_W{1'b1}}
                                                            : w_shifted[ENERGY_W-1:0];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_c6;

endmodule

>>> design/vtep_cell.sv
// One CORDIC vectoring step as a pipeline cell; energy and flag ride along.
// Depends on vtep_pkg.
module vtep_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vtep_pkg::t_cord i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output vtep_pkg::t_cord o_data
);
    import vtep_pkg::*;

    logic                   r_valid;
    t_cord                  r_data;
    logic signed [XY_W-1:0] w_dx, w_dy;
    logic signed [Z_W-1:0]  w_ang;
    t_cord                  n_data;

    assign o_ready = !r_valid || i_ready;

    // Rotate toward y = 0 (floor shifts)
    always_comb begin
        w_dx   = i_data.y >>> STEP;
        w_dy   = i_data.x >>> STEP;
        w_ang  = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[STEP]});
        n_data = i_data;
        if (!i_data.y[XY_W-1]) begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + w_ang;
        end else begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/velocity_to_energy_pitch_core.sv
// Kinetic energy and pitch angle from particle velocity.
// Pipeline: seed stage, five energy stages, one cell per CORDIC step, output
// register. One transfer per cycle sustained while m_axis_tready holds, set
// by the one-step-per-cell CORDIC chain. Stages with no item absorb stalls.
// Synchronous active-low reset empties the pipeline and sets coefficient 1,
// shift 0. Depends on vtep_pkg, vtep_energy and vtep_cell.
module velocity_to_energy_pitch_core #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] vel_para, [63:32] vel_perp
    input  logic [2*vtep_pkg::VEL_W-1:0]        s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [47:0] energy, [71:48] pitch
    output logic [vtep_pkg::ENERGY_W+vtep_pkg::PITCH_W-1:0] m_axis_tdata,
    // [0] zero_velocity
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vtep_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vtep_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import vtep_pkg::*;

    // Configuration registers
    logic [COEFF_W-1:0] r_coeff;
    logic [SHIFT_W-1:0] r_shift;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= COEFF_W'(1);
            r_shift <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ENERGY_COEFF) begin
                r_coeff <= i_cfg_data[COEFF_W-1:0];
            end else if (i_cfg_index == CFG_ENERGY_SHIFT) begin
                r_shift <= i_cfg_data[SHIFT_W-1:0];
            end
        end
    end

    // Cell chain links: index 0 is the front end output
    t_cord                 w_cd  [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] w_vld;
    logic [CORDIC_STEPS:0] w_rdy;

    vtep_energy u_energy (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_vel_para ($signed(s_axis_tdata[VEL_W-1:0])),
        .i_vel_perp ($signed(s_axis_tdata[2*VEL_W-1:VEL_W])),
        .i_coeff    (r_coeff),
        .i_shift    (r_shift),
        .o_valid    (w_vld[0]),
        .i_ready    (w_rdy[0]),
        .o_data     (w_cd[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        vtep_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    // Output stage: clamp angle, force zero for a zero vector
    logic                r_out_valid;
    logic [ENERGY_W-1:0] r_energy;
    logic [PITCH_W-1:0]  r_pitch;
    logic                r_zero;
    logic [PITCH_W-1:0]  w_pitch;
    t_cord               w_last;

    assign w_last = w_cd[CORDIC_STEPS];
    assign w_rdy[CORDIC_STEPS] = !r_out_valid || m_axis_tready;

    always_comb begin
        priority if (w_last.zero || w_last.z[Z_W-1]) begin
            w_pitch = '0;
        end else if (w_last.z > $signed({{(Z_W-PITCH_W){1'b0}}, PITCH_MAX})) begin
            w_pitch = PITCH_MAX;
        end else begin
            w_pitch = w_last.z[PITCH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy[CORDIC_STEPS]) begin
            r_out_valid <= w_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[CORDIC_STEPS] && w_vld[CORDIC_STEPS]) begin
            r_energy <= w_last.energy;
            r_pitch  <= w_pitch;
            r_zero   <= w_last.zero;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_pitch, r_energy};
    assign m_axis_tuser  = r_zero;

    // Zero-velocity results carry zero energy and zero angle
    a_zero_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("zero-velocity result with nonzero payload");

    // Angle never leaves 0..180 degrees
    a_pitch_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ENERGY_W+PITCH_W-1:ENERGY_W] <= PITCH_MAX))
        else $error("pitch out of range");

    // Input back-pressure only when the whole chain is full behind a stalled output
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&w_vld)))
        else $error("input stalled with room in the pipeline");

endmodule
